// ----- hdl/abst_pkg.sv -----
// Shared types and constants for the array binary search tree core.
// Holds result status codes and the command/status structs that join
// the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abst_pkg;

    // Field widths
    localparam int KEY_W       = 32;
    localparam int SLOT_W      = 10;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // Action codes (input tuser)
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    // Result status codes (output tuser)
    typedef enum logic [STATUS_W-1:0] {
        STS_INSERTED  = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_FULL      = 3'd2,
        STS_ZERO      = 3'd3,
        STS_FOUND     = 3'd4,
        STS_NOTFOUND  = 3'd5
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;     // write zero at the clear counter and advance it
        logic start;     // capture the input item, read the root slot
        logic step;      // compare one tree level, read the next slot
        logic out_load;  // move the finished result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;   // clear counter sits on the last slot
        logic zero_key;   // incoming key is the reserved empty value
        logic walk_done;  // current level ends the walk
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/array_bst_insert_find_core.sv -----
// Top level of the array binary search tree core: stream ports,
// controller (abst_ctrl) and datapath (abst_dp). Uses abst_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Binary search tree held in an array: root at slot 1, children of slot i
// at 2i and 2i+1, key 0 means empty. Each input item inserts (tuser 0) or
// finds (tuser 1) a signed 32-bit key; each item gives exactly one result
// item with a status in tuser and a slot in tdata. After reset the block
// clears its node memory, one slot per cycle, and holds s_axis_tready low
// until every slot is cleared. An item then passes an accept state, one
// look step per tree level visited (one memory read each, up to
// $clog2(CAPACITY)+1 levels, the last one only to see the walk leave the
// array) and a result state; a zero key goes from accept straight to the
// result state. One item is in flight at a time, and the next item can be
// accepted while the previous result waits in the output register.
module array_bst_insert_find_core #(
    parameter int CAPACITY = 1024
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [abst_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [31:0] key
    input  wire                                  s_axis_tuser,  // [0] action
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [abst_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [9:0] slot
    output logic [abst_pkg::STATUS_W-1:0]        m_axis_tuser   // [2:0] status
);
    import abst_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    t_status           w_out_status;
    logic [SLOT_W-1:0] w_out_slot;

    // sequencing
    abst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // memory and compare
    abst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_action  (s_axis_tuser),
        .i_in_key     (s_axis_tdata[KEY_W-1:0]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (w_out_status),
        .o_out_slot   (w_out_slot)
    );

    // output packing
    assign m_axis_tdata = OUT_TDATA_W'(w_out_slot);
    assign m_axis_tuser = w_out_status;

`ifndef ASSERT_OFF
    // controller issues at most one command per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // statuses without a slot report slot zero
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STS_FULL || m_axis_tuser == STS_ZERO
            || m_axis_tuser == STS_NOTFOUND) |-> m_axis_tdata == '0)
        else $error("nonzero slot with full, zero-key or not-found status");

    // status codes stay in the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= STS_NOTFOUND)
        else $error("undefined result status");
`endif

endmodule

`default_nettype wire

// ----- hdl/abst_ctrl.sv -----
// Controller for the array binary search tree core.
// One-hot state machine issuing t_dp_cmd to abst_dp; uses abst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abst_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  abst_pkg::t_dp_sts i_sts,
    output abst_pkg::t_dp_cmd o_cmd
);
    import abst_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_LOOK   = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.zero_key ? S_RESULT : S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/abst_dp.sv -----
// Datapath for the array binary search tree core: node memory, walk
// position, key compare, result and output registers. Uses abst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abst_dp #(
    parameter int CAPACITY = 1024
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  abst_pkg::t_dp_cmd              i_cmd,
    output abst_pkg::t_dp_sts              o_sts,
    input  wire                            i_in_action,
    input  wire  [abst_pkg::KEY_W-1:0]     i_in_key,
    input  wire                            i_out_ready,
    output logic                           o_out_valid,
    output abst_pkg::t_status              o_out_status,
    output logic [abst_pkg::SLOT_W-1:0]    o_out_slot
);
    import abst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    // the walk position can reach 2*CAPACITY-1 before it stops
    localparam int PW = $clog2(2 * CAPACITY);

    // node store and its registered read port
    logic [KEY_W-1:0] r_mem [CAPACITY];
    logic [KEY_W-1:0] r_rdata;

    logic [AW-1:0]    r_clr_cnt;
    logic [KEY_W-1:0] r_key;
    logic             r_act;
    logic [PW-1:0]    r_pos;
    t_status          r_res_status;
    logic [SLOT_W-1:0] r_res_slot;

    logic             w_in_range;
    logic             w_empty;
    logic             w_hit;
    logic             w_less;
    logic             w_done;
    logic             w_ins;
    logic [PW-1:0]    w_next_pos;
    t_status          w_status;
    logic [SLOT_W-1:0] w_slot;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [KEY_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr;

    // one tree level: compare the stored key with the search key
    always_comb begin
        w_in_range = (r_pos < PW'(CAPACITY));
        w_empty    = (r_rdata == '0);
        w_hit      = (r_rdata == r_key);
        w_less     = ($signed(r_key) < $signed(r_rdata));
        w_done     = !w_in_range || w_empty || w_hit;
        w_next_pos = {r_pos[PW-2:0], !w_less};
        w_ins      = 1'b0;
        w_status   = STS_NOTFOUND;
        w_slot     = '0;
        if (w_in_range && w_hit) begin
            w_status = (r_act == ACT_FIND) ? STS_FOUND : STS_DUPLICATE;
            w_slot   = SLOT_W'(r_pos);
        end else if (r_act == ACT_FIND) begin
            w_status = STS_NOTFOUND;
        end else if (w_in_range) begin
            w_status = STS_INSERTED;
            w_slot   = SLOT_W'(r_pos);
            w_ins    = 1'b1;
        end else begin
            w_status = STS_FULL;
        end
    end

    // memory port selection
    always_comb begin
        w_we    = i_cmd.clear || (i_cmd.step && w_done && w_ins);
        w_waddr = i_cmd.clear ? r_clr_cnt : AW'(r_pos);
        w_wdata = i_cmd.clear ? '0 : r_key;
        w_raddr = i_cmd.start ? AW'(1) : AW'(w_next_pos);
    end

    // node memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // item capture, walk position and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key        <= i_in_key;
            r_act        <= i_in_action;
            r_pos        <= PW'(1);
            r_res_status <= STS_ZERO;
            r_res_slot   <= '0;
        end else if (i_cmd.step) begin
            if (w_done) begin
                r_res_status <= w_status;
                r_res_slot   <= w_slot;
            end else begin
                r_pos <= w_next_pos;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_status <= r_res_status;
            o_out_slot   <= r_res_slot;
        end
    end

    // status back to the controller
    always_comb begin
        o_sts.clr_done  = (r_clr_cnt == AW'(CAPACITY - 1));
        o_sts.zero_key  = (i_in_key == '0);
        o_sts.walk_done = w_done;
        o_sts.out_free  = !o_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire
